// ===== sv/spq_pkg.sv =====
// Shared types and codes for the stable priority queue.
package spq_pkg;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic        [15:0] item_handle;
        logic signed [15:0] type_in;
        logic signed [15:0] priority_in;
    } t_in_item;

    typedef struct packed {
        logic        [1:0]  status;
        logic        [4:0]  count;
        logic        [15:0] item_out;
        logic signed [15:0] type_out;
        logic signed [15:0] priority_out;
    } t_out_item;

    typedef struct packed {
        logic latch;  // capture the incoming item
        logic exec;   // apply the captured item and load the result
    } t_spq_cmd;

endpackage

// ===== sv/spq_ctrl.sv =====
// Handshake and sequencing controller for the priority queue.
module spq_ctrl import spq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_spq_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_go;

    // result slot free, or being emptied this cycle
    assign w_go = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_go) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/spq_dpath.sv =====
// Sorted cell array, parallel compares and result register.
module spq_dpath import spq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_spq_cmd  i_cmd,
    input  t_in_item  i_in_item,
    output t_out_item o_out_item
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_in_item           r_req;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic        [15:0] r_hdl [CAPACITY];
    logic signed [15:0] r_typ [CAPACITY];
    logic signed [15:0] r_pri [CAPACITY];
    t_out_item          r_out;

    logic [CAPACITY-1:0] w_valid, w_le, w_hit;
    logic                w_full, w_empty, w_do_ins, w_do_rem;
    logic [1:0]          w_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_in_item;
        end
    end

    // per-cell compares against the captured item
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cmp
        assign w_valid[gi] = (CW'(gi) < r_cnt);
        assign w_le[gi]    = w_valid[gi] && (r_pri[gi] <= r_req.priority_in);
        assign w_hit[gi]   = w_valid[gi] && (r_hdl[gi] == r_req.item_handle);
    end

    assign w_full  = (r_cnt == CW'(CAPACITY));
    assign w_empty = (r_cnt == '0);

    always_comb begin
        if (r_req.kind == KIND_INSERT) begin
            if (r_req.item_handle == 16'd0) begin
                w_status = ST_REJECT;
            end else if (|w_hit) begin
                w_status = ST_REJECT;
            end else if (w_full) begin
                w_status = ST_FULL;
            end else begin
                w_status = ST_DONE;
            end
        end else begin
            w_status = w_empty ? ST_EMPTY : ST_DONE;
        end
    end

    assign w_do_ins = i_cmd.exec && (r_req.kind == KIND_INSERT) && (w_status == ST_DONE);
    assign w_do_rem = i_cmd.exec && (r_req.kind == KIND_REMOVE) && (w_status == ST_DONE);

    always_comb begin
        n_cnt = r_cnt;
        if (w_do_ins) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_do_rem) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // insert: cells past the slot move up one; remove: every cell but the last moves down one
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (w_do_ins && !w_le[gi]) begin
                if (gi == 0) begin
                    r_hdl[gi] <= r_req.item_handle;
                    r_typ[gi] <= r_req.type_in;
                    r_pri[gi] <= r_req.priority_in;
                end else if (w_le[(gi == 0) ? 0 : gi - 1]) begin
                    r_hdl[gi] <= r_req.item_handle;
                    r_typ[gi] <= r_req.type_in;
                    r_pri[gi] <= r_req.priority_in;
                end else begin
                    r_hdl[gi] <= r_hdl[(gi == 0) ? 0 : gi - 1];
                    r_typ[gi] <= r_typ[(gi == 0) ? 0 : gi - 1];
                    r_pri[gi] <= r_pri[(gi == 0) ? 0 : gi - 1];
                end
            end else if (w_do_rem && (gi < CAPACITY - 1)) begin
                r_hdl[gi] <= r_hdl[(gi < CAPACITY - 1) ? gi + 1 : gi];
                r_typ[gi] <= r_typ[(gi < CAPACITY - 1) ? gi + 1 : gi];
                r_pri[gi] <= r_pri[(gi < CAPACITY - 1) ? gi + 1 : gi];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out.status <= w_status;
            r_out.count  <= 5'(n_cnt);
            if (w_do_rem) begin
                r_out.item_out     <= r_hdl[0];
                r_out.type_out     <= r_typ[0];
                r_out.priority_out <= r_pri[0];
            end else begin
                r_out.item_out     <= '0;
                r_out.type_out     <= '0;
                r_out.priority_out <= '0;
            end
        end
    end

    assign o_out_item = r_out;

endmodule

// ===== sv/stable_priority_queue_top.sv =====
// Stable priority queue: top level joining the controller and the cell datapath.
// Each item is captured at acceptance, then executed and loaded into the result
// register once the result slot is free or being emptied at the output.
// Items are taken one at a time: the input stalls from capture until execute,
// and longer while a held result is stalled at the output.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// cell contents are left as they are and are never read before being written.
module stable_priority_queue_top import spq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // Commands from the controller to the datapath.
    t_spq_cmd w_cmd;

    // Controller: one item in flight; the result register frees the input side
    // as soon as the result is loaded.
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // Datapath: row of cells kept in ascending priority order, equal priorities
    // in arrival order; all cells compare in parallel and shift by one place.
    spq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule
